// File: sv/lzfgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzfgd_pkg
// Shared types and constants for the LZSS flag-group decoder.
// ----------------------------------------------------------------------------
package lzfgd_pkg;

   // Field widths of a reference (high byte + low byte).
   localparam int DIST_W    = 12;
   localparam int LEN_W     = 4;
   localparam int MIN_MATCH = 3;

   // Copy counter holds (length - 1): up to 17.
   localparam int REMAIN_W  = 5;

   // Stream parser position.
   typedef enum logic [1:0] {
      PH_FLAG = 2'd0,
      PH_ITEM = 2'd1,
      PH_LOW  = 2'd2
   } phase_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_ACCEPT = 2'd0,
      ST_READ   = 2'd1,
      ST_COPY   = 2'd2,
      ST_EMIT   = 2'd3
   } state_type;

endpackage
`default_nettype wire

// File: sv/lzfgd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzfgd_req_if / lzfgd_rsp_if
// Valid/ready channels for compressed input words and decoded output words.
// ----------------------------------------------------------------------------
interface lzfgd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzfgd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       end_of_stream;

   modport source (output valid, output out_byte, output last, output end_of_stream,
                   input ready);
   modport sink   (input valid, input out_byte, input last, input end_of_stream,
                   output ready);
endinterface
`default_nettype wire

// File: sv/lzss_flag_group_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzss_flag_group_decoder
// LZSS decompressor, flag groups of eight items, 4 KB history window.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one compressed word per handshake: a flag word, a literal,
//   or one of the two words of a back reference. rsp carries decoded words
//   with last (final word caused by that input word) and end_of_stream.
//   Flag words and reference high words give no output.
//   A literal is shown on rsp in the cycle after it is taken.
//   A reference low word yields 3..18 words; each goes through a history
//   read, registered read data and output hold, because the single
//   history RAM is read and written once per copied word, and overlapped
//   copies must see the word written just before.
//   req.ready is high only while no output word is pending, so the block
//   holds one item at a time. A stalled rsp simply holds its word; nothing
//   is lost or repeated.
//   Reset (synchronous) returns the parser to "expect flag", clears the
//   output count and write pointer. The history RAM is not cleared: reads
//   beyond the output count return zero instead.
//   A zero distance emits one end marker word and restarts the stream.
// ----------------------------------------------------------------------------
module lzss_flag_group_decoder
   import lzfgd_pkg::*;
#(
   parameter int HISTORY_DEPTH = 4096
) (
   input  wire           clock,
   input  wire           reset,
   lzfgd_req_if.sink     req,
   lzfgd_rsp_if.source   rsp
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] COUNT_MAX = CW'(HISTORY_DEPTH);

   // Sequencer and parser state
   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [7:0]            flag_ff, flag_in;
   logic [2:0]            idx_ff, idx_in;
   logic [7:0]            high_ff, high_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         wp_ff, wp_in;

   // Copy in progress
   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic [REMAIN_W-1:0]   remain_ff, remain_in;
   logic                  more_ff, more_in;

   // Output word register
   logic [7:0]            out_byte_ff, out_byte_in;
   logic                  last_ff, last_in;
   logic                  eos_ff, eos_in;

   // History RAM
   logic [7:0]            hist_mem [HISTORY_DEPTH];
   logic [7:0]            rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [7:0]            mem_wdata;

   logic                  req_fire;
   logic [DIST_W-1:0]     ref_dist;
   logic [LEN_W-1:0]      ref_len;
   logic [2:0]            idx_next;
   phase_type             phase_next;
   logic [CW-1:0]         count_inc;
   logic [7:0]            copy_byte;

   assign req_fire = req.valid && req.ready;

   // Reference fields: distance = high word and upper nibble of low word.
   assign ref_dist = {high_ff, req.in_byte[7:LEN_W]};
   assign ref_len  = req.in_byte[LEN_W-1:0];

   // Advance to the next item of the flag group.
   assign idx_next   = (idx_ff == 3'd7) ? 3'd0 : idx_ff + 3'd1;
   assign phase_next = (idx_ff == 3'd7) ? PH_FLAG : PH_ITEM;

   // Saturating output count
   assign count_inc = (count_ff < COUNT_MAX) ? count_ff + CW'(1) : count_ff;

   // Source is before the start of the output: read as zero.
   assign rd_addr   = wp_ff - AW'(dist_ff);
   assign copy_byte = (CW'(dist_ff) > count_ff) ? 8'd0 : rd_data_ff;

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCEPT: begin
            if (req_fire && phase_ff == PH_ITEM && flag_ff[idx_ff]) begin
               state_in = ST_EMIT;
            end else if (req_fire && phase_ff == PH_LOW) begin
               state_in = (ref_dist == '0) ? ST_EMIT : ST_READ;
            end
         end
         ST_READ: state_in = ST_COPY;
         ST_COPY: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp.ready) begin
               state_in = more_ff ? ST_READ : ST_ACCEPT;
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath and parser updates
   // ------------------------------------------------------------------
   always_comb begin
      phase_in    = phase_ff;
      flag_in     = flag_ff;
      idx_in      = idx_ff;
      high_in     = high_ff;
      count_in    = count_ff;
      wp_in       = wp_ff;
      dist_in     = dist_ff;
      remain_in   = remain_ff;
      more_in     = more_ff;
      out_byte_in = out_byte_ff;
      last_in     = last_ff;
      eos_in      = eos_ff;
      mem_we      = 1'b0;
      mem_waddr   = wp_ff;
      mem_wdata   = req.in_byte;

      case (state_ff)
         ST_ACCEPT: begin
            if (req_fire) begin
               case (phase_ff)
                  PH_ITEM: begin
                     if (flag_ff[idx_ff]) begin
                        // literal: emit and store
                        out_byte_in = req.in_byte;
                        last_in     = 1'b1;
                        eos_in      = 1'b0;
                        more_in     = 1'b0;
                        mem_we      = 1'b1;
                        wp_in       = wp_ff + AW'(1);
                        count_in    = count_inc;
                        idx_in      = idx_next;
                        phase_in    = phase_next;
                     end else begin
                        high_in  = req.in_byte;
                        phase_in = PH_LOW;
                     end
                  end
                  PH_LOW: begin
                     if (ref_dist == '0) begin
                        // end marker
                        out_byte_in = 8'd0;
                        last_in     = 1'b1;
                        eos_in      = 1'b1;
                        more_in     = 1'b0;
                        phase_in    = PH_FLAG;
                        idx_in      = 3'd0;
                        count_in    = '0;
                        wp_in       = '0;
                     end else begin
                        dist_in   = ref_dist;
                        remain_in = REMAIN_W'(ref_len) + REMAIN_W'(MIN_MATCH - 1);
                     end
                  end
                  default: begin
                     flag_in  = req.in_byte;
                     idx_in   = 3'd0;
                     phase_in = PH_ITEM;
                  end
               endcase
            end
         end
         ST_COPY: begin
            out_byte_in = copy_byte;
            last_in     = (remain_ff == '0);
            eos_in      = 1'b0;
            more_in     = (remain_ff != '0);
            remain_in   = remain_ff - REMAIN_W'(1);
            mem_we      = 1'b1;
            mem_wdata   = copy_byte;
            wp_in       = wp_ff + AW'(1);
            count_in    = count_inc;
            if (remain_ff == '0) begin
               idx_in   = idx_next;
               phase_in = phase_next;
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Handshake outputs
   // ------------------------------------------------------------------
   always_comb begin
      req.ready         = (state_ff == ST_ACCEPT);
      rsp.valid         = (state_ff == ST_EMIT);
      rsp.out_byte      = out_byte_ff;
      rsp.last          = last_ff;
      rsp.end_of_stream = eos_ff;
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         phase_ff <= PH_FLAG;
         flag_ff  <= '0;
         idx_ff   <= '0;
         high_ff  <= '0;
         count_ff <= '0;
         wp_ff    <= '0;
         more_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         flag_ff  <= flag_in;
         idx_ff   <= idx_in;
         high_ff  <= high_in;
         count_ff <= count_in;
         wp_ff    <= wp_in;
         more_ff  <= more_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff     <= dist_in;
      remain_ff   <= remain_in;
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
      eos_ff      <= eos_in;
   end

   // History RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= hist_mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: sv/lzfgd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzfgd_checker
// Port-level checks for the LZSS flag-group decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lzfgd_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] rsp_out_byte,
   input wire       rsp_last,
   input wire       rsp_end_of_stream
);

   // stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last) && $stable(rsp_end_of_stream))
      else $error("rsp word changed while stalled");

   // one item at a time: no input taken while an output word waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while output pending");

   // end marker is a zero word closing its input
   a_eos_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_stream |-> rsp_last && rsp_out_byte == 8'd0)
      else $error("malformed end marker");

   // reset leaves no output pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   // after the end marker is taken the block waits for input
   a_eos_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_end_of_stream |=> req_ready)
      else $error("not ready after end marker");

endmodule

bind lzss_flag_group_decoder lzfgd_checker u_lzfgd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_out_byte      (rsp.out_byte),
   .rsp_last          (rsp.last),
   .rsp_end_of_stream (rsp.end_of_stream)
);
`default_nettype wire

// File: dv/lzss_flag_group_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_flag_group_decoder_test
// Self-checking bench for the LZSS flag-group decoder. Compressed words go in
// through the req channel. A behavioral decoder, with its own history window,
// predicts every decoded word. Each decoded word on rsp is checked in order.
// ----------------------------------------------------------------------------
module lzss_flag_group_decoder_test;
   import lzfgd_pkg::*;

   localparam int HIST_DEPTH   = 4096;
   localparam int DRAIN_CYCLES = 64;     // outlasts one full 18-word copy
   localparam int NOISY_WORDS  = 250;    // random part with idling on both sides
   localparam int QUIET_WORDS  = 130;    // random tail, no idling at all

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       eos;
   } decoded_word_type;

   logic clock = 1'b0;
   logic reset;

   lzfgd_req_if req_bus ();
   lzfgd_rsp_if rsp_bus ();

   lzss_flag_group_decoder #(
      .HISTORY_DEPTH(HIST_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Decoder state mirrored by the predictor
   // --------------------------------------------------------------------------
   phase_type     parse_phase;
   logic [7:0]    flag_bits;
   logic [2:0]    item_index;
   logic [7:0]    held_high;
   logic [12:0]   out_count;          // saturates at HIST_DEPTH
   logic [11:0]   wr_ptr;
   logic [7:0]    window [HIST_DEPTH];

   decoded_word_type decoded_due [$]; // predicted words not yet seen on rsp

   int words_sent     = 0;
   int words_checked  = 0;
   int markers_seen   = 0;
   int error_count    = 0;
   int ready_hold     = 0;
   bit no_idle        = 1'b0;

   function automatic void push_result(input logic [7:0] data, input logic last,
                                       input logic eos);
      decoded_word_type w;
      w.data = data;
      w.last = last;
      w.eos  = eos;
      decoded_due.push_back(w);
   endfunction

   // Every emitted word goes into the window and bumps the saturating count.
   function automatic void store_byte(input logic [7:0] v);
      window[wr_ptr] = v;
      wr_ptr = wr_ptr + 12'd1;
      if (out_count < HIST_DEPTH) begin
         out_count = out_count + 13'd1;
      end
   endfunction

   function automatic void next_item();
      if (item_index == 3'd7) begin
         item_index  = 3'd0;
         parse_phase = PH_FLAG;
      end else begin
         item_index  = item_index + 3'd1;
         parse_phase = PH_ITEM;
      end
   endfunction

   // Predict the decoded words caused by one accepted compressed word.
   function automatic void decode_word(input logic [7:0] b);
      logic [11:0] ref_distance;
      logic [7:0]  v;
      int          len;
      case (parse_phase)
         PH_ITEM: begin
            if (flag_bits[item_index]) begin
               push_result(b, 1'b1, 1'b0);
               store_byte(b);
               next_item();
            end else begin
               held_high   = b;
               parse_phase = PH_LOW;
            end
         end
         PH_LOW: begin
            ref_distance = {held_high, b[7:4]};
            len          = int'(b[3:0]) + MIN_MATCH;
            if (ref_distance == 12'd0) begin
               // end marker: one word, stream restarts
               push_result(8'h00, 1'b1, 1'b1);
               parse_phase = PH_FLAG;
               item_index  = 3'd0;
               out_count   = 13'd0;
               wr_ptr      = 12'd0;
            end else begin
               // byte-by-byte so overlapping copies see fresh output;
               // reaching back past the start of output yields zero
               for (int j = 0; j < len; j++) begin
                  v = (13'(ref_distance) > out_count) ? 8'h00
                                                      : window[wr_ptr - ref_distance];
                  store_byte(v);
                  push_result(v, j == len - 1, 1'b0);
               end
               next_item();
            end
         end
         default: begin
            flag_bits   = b;
            item_index  = 3'd0;
            parse_phase = PH_ITEM;
         end
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Input side: one word per call, optional idle gap ahead of it
   // --------------------------------------------------------------------------
   task automatic send_word(input logic [7:0] b);
      int gap;
      gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid   <= 1'b0;
         req_bus.in_byte <= 8'($urandom);
      end
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      decode_word(b);
      words_sent++;
   endtask

   task automatic send_reference(input logic [11:0] distance, input logic [3:0] len_code);
      send_word(distance[11:4]);
      send_word({distance[3:0], len_code});
   endtask

   // Short look-backs most often, some anywhere in the valid window, some reaching
   // past the start of output (zero fill). Never zero: that is the end marker.
   function automatic logic [11:0] pick_distance();
      int sel;
      int have;
      sel  = $urandom_range(0, 9);
      have = int'(out_count);
      if (have != 0 && sel < 4) return 12'($urandom_range(1, (have < 24) ? have : 24));
      if (have != 0 && sel < 7) return 12'($urandom_range(1, (have < 4095) ? have : 4095));
      if (have < 4095 && sel < 9) return 12'($urandom_range(have + 1, 4095));
      return 12'($urandom_range(1, 4095));
   endfunction

   // Well-formed stream of n_items items with random content. With close set,
   // item n_items is the end marker (its flag bit is forced clear).
   // dense_refs gives mostly references, all of them full-length.
   task automatic send_stream(input int n_items, input bit close, input bit dense_refs);
      logic [7:0] flag;
      logic [3:0] len_code;
      for (int k = 0; k <= n_items; k++) begin
         if (k % 8 == 0) begin
            flag = dense_refs ? 8'($urandom & $urandom & $urandom) : 8'($urandom);
            if (close && n_items - k < 8) flag[n_items - k] = 1'b0;
            if (k < n_items || close) send_word(flag);
         end
         if (k == n_items) begin
            if (close) send_reference(12'h000, 4'($urandom));
         end else if (flag[k % 8]) begin
            send_word(8'($urandom));
         end else begin
            len_code = dense_refs ? 4'hF : 4'($urandom);
            send_reference(pick_distance(), len_code);
         end
      end
   endtask

   // --------------------------------------------------------------------------
   // Output side: random stall bursts, none in quiet mode
   // --------------------------------------------------------------------------
   always @(negedge clock) begin
      if (no_idle) begin
         rsp_bus.ready <= 1'b1;
      end else if (ready_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         ready_hold--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_bus.ready <= 1'b0;
         ready_hold = $urandom_range(0, 2);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare each decoded word with the oldest prediction (byte/last/end).
   always @(posedge clock) begin
      decoded_word_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (decoded_due.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word: expected none, got byte %02h last %b end %b",
                     $time, rsp_bus.out_byte, rsp_bus.last, rsp_bus.end_of_stream);
         end else begin
            want = decoded_due.pop_front();
            words_checked++;
            if (want.eos) markers_seen++;
            if (rsp_bus.out_byte !== want.data || rsp_bus.last !== want.last ||
                rsp_bus.end_of_stream !== want.eos) begin
               error_count++;
               $display("%0t: mismatch: expected %02h/%b/%b, got %02h/%b/%b",
                        $time, want.data, want.last, want.eos,
                        rsp_bus.out_byte, rsp_bus.last, rsp_bus.end_of_stream);
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------

   // Literals at both extremes, an overlapped run (distance 1, max length),
   // a copy that starts before the output and then reads real history,
   // a far reference into empty window, then the end marker.
   task automatic test_literals_and_copies();
      send_word(8'h03);
      send_word(8'hFF);
      send_word(8'h00);
      send_reference(12'd1, 4'hF);
      send_reference(12'd21, 4'h0);
      send_reference(12'hFFF, 4'h0);
      send_reference(12'h000, 4'h5);
   endtask

   // Input stops between the two words of a reference: nothing may come out
   // while it waits. The low word then completes an end marker.
   task automatic test_truncated_reference();
      send_word(8'hFD);
      send_word(8'h5A);
      send_word(8'h00);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (decoded_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      send_word(8'h00);
   endtask

   // All-literal group: item index runs through 7 and back to a flag word.
   task automatic test_full_literal_group();
      send_word(8'hFF);
      send_word(8'h01);
      send_word(8'h80);
      send_word(8'h7F);
      send_word(8'hFE);
      send_word(8'h55);
      send_word(8'hAA);
      send_word(8'h00);
      send_word(8'hFF);
   endtask

   // Mostly well-formed streams; some raw noise and some cut-off streams
   // that leave the parser mid-group for whatever follows.
   task automatic test_random_streams(input int budget);
      int start;
      int sel;
      start = words_sent;
      while (words_sent - start < budget) begin
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            repeat ($urandom_range(1, 6)) send_word(8'($urandom));
         end else if (sel == 1) begin
            send_stream($urandom_range(1, 6), 1'b0, 1'b0);
         end else begin
            send_stream($urandom_range(2, 30), 1'b1, 1'b0);
         end
      end
   endtask

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.in_byte = 8'h00;
      reset           = 1'b1;
      parse_phase     = PH_FLAG;
      flag_bits       = 8'h00;
      item_index      = 3'd0;
      held_high       = 8'h00;
      out_count       = 13'd0;
      wr_ptr          = 12'd0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_literals_and_copies();
      test_truncated_reference();
      test_full_literal_group();
      test_random_streams(NOISY_WORDS);
      no_idle = 1'b1;
      test_random_streams(QUIET_WORDS);

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (decoded_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: sent %0d compressed words, checked %0d decoded words, %0d end markers",
               words_sent, words_checked, markers_seen);
      $display("tb: literals, overlapped and zero-fill copies, cut-off input, random streams");
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: far above the slowest legal run.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// File: filelist.f
sv/lzfgd_pkg.sv
sv/lzfgd_if.sv
sv/lzss_flag_group_decoder.sv
sv/lzfgd_checker.sv
dv/lzss_flag_group_decoder_test.sv
